@@ design/gcva_pkg.sv @@
// Package for the gradient center vote accumulator.
// Holds the fixed field widths, register indexes, controller states and the
// structs passed between the vote pipeline and the top level. No dependencies.
package gcva_pkg;

	localparam int COORD_W  = 6;
	localparam int WEIGHT_W = 8;
	localparam int GRAD_W   = 16;
	localparam int SCORE_W  = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_WEIGHT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_DIVISOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT  = 3'd3;

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_VOTE  = 5'b00100,
		ST_SCANW = 5'b01000,
		ST_SCAN  = 5'b10000
	} state_t;

	// Parameters of the point being voted, held for the whole point.
	typedef struct packed {
		logic [COORD_W-1:0]       px;
		logic [COORD_W-1:0]       py;
		logic [WEIGHT_W-1:0]      mult;
		logic [WEIGHT_W-1:0]      divisor;
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
	} point_t;

	// One finished vote leaving the vote pipeline.
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [SCORE_W-1:0] value;
	} vote_t;

endpackage

@@ design/gradient_center_vote_accumulator_top.sv @@
// Top level of the gradient center vote accumulator: configuration, controller,
// score store read-modify-write and the argmax scan with clearing.
// Depends on gcva_pkg, gcva_ram and gcva_vote.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid, in_ready, point_x .. last_point            | request in
//  out     | out_valid, out_ready, center_x, center_y, best_score | request out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data            | request in
//
// A point with a nonzero gradient makes active_width * active_height store
// updates, one read-modify-write per cycle on the score RAM, once the vote
// pipeline (two bit-per-stage dividers) has filled.
// A last point adds a scan over all MAX_WIDTH * MAX_HEIGHT entries that reads the
// maximum and writes zeros back. After reset the same pass clears the store
// with in_ready low; cfg_ready is always high.
// A result waiting on out_ready stalls only the next readout, not the voting.
module gradient_center_vote_accumulator_top #(
	parameter int MAX_WIDTH      = 64,
	parameter int MAX_HEIGHT     = 64,
	parameter int GRAD_FRAC_BITS = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [gcva_pkg::COORD_W-1:0]           point_x,
	input  logic [gcva_pkg::COORD_W-1:0]           point_y,
	input  logic [gcva_pkg::WEIGHT_W-1:0]          pixel_weight,
	input  logic signed [gcva_pkg::GRAD_W-1:0]     grad_x,
	input  logic signed [gcva_pkg::GRAD_W-1:0]     grad_y,
	input  logic                                   last_point,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [gcva_pkg::COORD_W-1:0]           center_x,
	output logic [gcva_pkg::COORD_W-1:0]           center_y,
	output logic [gcva_pkg::SCORE_W-1:0]           best_score,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [gcva_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [gcva_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CX_W   = $clog2(MAX_WIDTH);
	localparam int CY_W   = $clog2(MAX_HEIGHT);
	localparam int AWIN_W = $clog2(MAX_WIDTH + 1);
	localparam int AHIN_W = $clog2(MAX_HEIGHT + 1);
	localparam int WC_W   = ((AWIN_W > 7) ? AWIN_W : 7) + 1;
	localparam int HC_W   = ((AHIN_W > 7) ? AHIN_W : 7) + 1;

	// Configuration registers.
	logic       en_q;
	logic [7:0] div_q;
	logic [6:0] aw_q;
	logic [6:0] ah_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b1;
			div_q <= 8'd1;
			aw_q  <= 7'd50;
			ah_q  <= 7'd50;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gcva_pkg::CFG_ENABLE_WEIGHT:  en_q  <= cfg_data[0];
				gcva_pkg::CFG_WEIGHT_DIVISOR: div_q <= cfg_data;
				gcva_pkg::CFG_ACTIVE_WIDTH:   aw_q  <= cfg_data[6:0];
				gcva_pkg::CFG_ACTIVE_HEIGHT:  ah_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Window size clamped to 1 .. MAX.
	logic [AWIN_W-1:0] win_w;
	logic [AHIN_W-1:0] win_h;

	always_comb begin
		if (aw_q == '0) begin
			win_w = AWIN_W'(1);
		end else if (WC_W'(aw_q) > WC_W'(MAX_WIDTH)) begin
			win_w = AWIN_W'(MAX_WIDTH);
		end else begin
			win_w = AWIN_W'(aw_q);
		end
		if (ah_q == '0) begin
			win_h = AHIN_W'(1);
		end else if (HC_W'(ah_q) > HC_W'(MAX_HEIGHT)) begin
			win_h = AHIN_W'(MAX_HEIGHT);
		end else begin
			win_h = AHIN_W'(ah_q);
		end
	end

	// Controller.
	gcva_pkg::state_t state_q;
	gcva_pkg::point_t point_q;
	logic             point_last_q;
	logic             acc;
	logic             zero_grad;
	logic             start;

	assign in_ready  = (state_q == gcva_pkg::ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign zero_grad = (grad_x == '0) && (grad_y == '0);
	assign start     = acc && !zero_grad;

	// Point register, with the weight factors resolved at acceptance.
	always_ff @(posedge clk) begin
		if (acc) begin
			point_q.px      <= point_x;
			point_q.py      <= point_y;
			point_q.gx      <= grad_x;
			point_q.gy      <= grad_y;
			point_q.mult    <= en_q ? pixel_weight : 8'd1;
			point_q.divisor <= (!en_q || div_q == '0) ? 8'd1 : div_q;
		end
	end

	// Vote pipeline.
	gcva_pkg::vote_t   vote;
	logic [ADDR_W-1:0] vote_addr;

	gcva_vote #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_HEIGHT    (MAX_HEIGHT),
		.GRAD_FRAC_BITS(GRAD_FRAC_BITS)
	) u_vote (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.point    (point_q),
		.win_w    (win_w),
		.win_h    (win_h),
		.vote     (vote),
		.vote_addr(vote_addr)
	);

	// Score store.
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [gcva_pkg::SCORE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]            ram_raddr;
	logic [gcva_pkg::SCORE_W-1:0] ram_rdata;

	gcva_ram #(
		.WIDTH(gcva_pkg::SCORE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Read-modify-write stage: the read was issued in the previous cycle, add and write.
	logic                         rmw_v_s1;
	logic                         rmw_last_s1;
	logic [ADDR_W-1:0]            rmw_addr_s1;
	logic [gcva_pkg::SCORE_W-1:0] rmw_val_s1;
	logic [gcva_pkg::SCORE_W:0]   rmw_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmw_v_s1 <= 1'b0;
		end else begin
			rmw_v_s1 <= vote.valid;
		end
	end

	always_ff @(posedge clk) begin
		rmw_last_s1 <= vote.last;
		rmw_addr_s1 <= vote_addr;
		rmw_val_s1  <= vote.value;
	end

	assign rmw_sum = (gcva_pkg::SCORE_W + 1)'(ram_rdata) + (gcva_pkg::SCORE_W + 1)'(rmw_val_s1);

	// Scan: reads every entry in address order, tracks the maximum, writes zero.
	logic              issuing_q;
	logic [ADDR_W-1:0] scan_addr_q;
	logic [CX_W-1:0]   scan_cx_q;
	logic [CY_W-1:0]   scan_cy_q;
	logic              scan_end;
	logic              scan_v_s1;
	logic              scan_last_s1;
	logic [ADDR_W-1:0] scan_addr_s1;
	logic [CX_W-1:0]   scan_cx_s1;
	logic [CY_W-1:0]   scan_cy_s1;
	logic              scan_start;
	logic              scan_done;

	assign scan_end   = (scan_addr_q == ADDR_W'(DEPTH - 1));
	assign scan_start = (state_q == gcva_pkg::ST_SCANW) && !out_valid;
	assign scan_done  = scan_v_s1 && scan_last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q   <= 1'b1;
			scan_addr_q <= '0;
			scan_cx_q   <= '0;
			scan_cy_q   <= '0;
			scan_v_s1   <= 1'b0;
		end else begin
			scan_v_s1 <= issuing_q;
			if (scan_start) begin
				issuing_q   <= 1'b1;
				scan_addr_q <= '0;
				scan_cx_q   <= '0;
				scan_cy_q   <= '0;
			end else if (issuing_q) begin
				if (scan_end) begin
					issuing_q <= 1'b0;
				end
				scan_addr_q <= scan_addr_q + 1'b1;
				if (scan_cx_q == CX_W'(MAX_WIDTH - 1)) begin
					scan_cx_q <= '0;
					scan_cy_q <= scan_cy_q + 1'b1;
				end else begin
					scan_cx_q <= scan_cx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_last_s1 <= scan_end;
		scan_addr_s1 <= scan_addr_q;
		scan_cx_s1   <= scan_cx_q;
		scan_cy_s1   <= scan_cy_q;
	end

	// Memory port selection.
	always_comb begin
		ram_raddr = issuing_q ? scan_addr_q : vote_addr;
		ram_we    = rmw_v_s1 || scan_v_s1;
		ram_waddr = rmw_v_s1 ? rmw_addr_s1 : scan_addr_s1;
		if (!rmw_v_s1) begin
			ram_wdata = '0;
		end else if (rmw_sum[gcva_pkg::SCORE_W]) begin
			ram_wdata = gcva_pkg::SCORE_MAX;
		end else begin
			ram_wdata = rmw_sum[gcva_pkg::SCORE_W-1:0];
		end
	end

	// Running maximum over the active window; strict compare keeps the first.
	logic [gcva_pkg::SCORE_W-1:0] best_q;
	logic [CX_W-1:0]              bx_q;
	logic [CY_W-1:0]              by_q;
	logic                         upd;
	logic [gcva_pkg::SCORE_W-1:0] best_n;
	logic [CX_W-1:0]              bx_n;
	logic [CY_W-1:0]              by_n;

	assign upd = scan_v_s1 && (AWIN_W'(scan_cx_s1) < win_w) && (AHIN_W'(scan_cy_s1) < win_h)
		&& (ram_rdata > best_q);
	assign best_n = upd ? ram_rdata : best_q;
	assign bx_n   = upd ? scan_cx_s1 : bx_q;
	assign by_n   = upd ? scan_cy_s1 : by_q;

	always_ff @(posedge clk) begin
		if (scan_start) begin
			best_q <= '0;
			bx_q   <= '0;
			by_q   <= '0;
		end else begin
			best_q <= best_n;
			bx_q   <= bx_n;
			by_q   <= by_n;
		end
	end

	// Output register.
	logic                         out_valid_q;
	logic [gcva_pkg::COORD_W-1:0] cx_out_q;
	logic [gcva_pkg::COORD_W-1:0] cy_out_q;
	logic [gcva_pkg::SCORE_W-1:0] score_out_q;
	logic                         report;

	assign report = (state_q == gcva_pkg::ST_SCAN) && scan_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			cx_out_q    <= gcva_pkg::COORD_W'(bx_n);
			cy_out_q    <= gcva_pkg::COORD_W'(by_n);
			score_out_q <= best_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign center_x   = cx_out_q;
	assign center_y   = cy_out_q;
	assign best_score = score_out_q;

	// State transitions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gcva_pkg::ST_CLEAR;
			point_last_q <= 1'b0;
		end else begin
			unique case (state_q)
				gcva_pkg::ST_CLEAR: begin
					if (scan_done) begin
						state_q <= gcva_pkg::ST_IDLE;
					end
				end
				gcva_pkg::ST_IDLE: begin
					if (acc) begin
						point_last_q <= last_point;
						if (!zero_grad) begin
							state_q <= gcva_pkg::ST_VOTE;
						end else if (last_point) begin
							state_q <= gcva_pkg::ST_SCANW;
						end
					end
				end
				gcva_pkg::ST_VOTE: begin
					if (rmw_v_s1 && rmw_last_s1) begin
						state_q <= point_last_q ? gcva_pkg::ST_SCANW : gcva_pkg::ST_IDLE;
					end
				end
				gcva_pkg::ST_SCANW: begin
					if (!out_valid) begin
						state_q <= gcva_pkg::ST_SCAN;
					end
				end
				gcva_pkg::ST_SCAN: begin
					if (scan_done) begin
						state_q <= gcva_pkg::ST_IDLE;
					end
				end
				default: state_q <= gcva_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/gcva_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the score store. No dependencies.
module gcva_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ design/gcva_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// The caller guarantees the quotient fits in QUO_W bits. No dependencies.
module gcva_div #(
	parameter int NUM_W = 52,
	parameter int DEN_W = 19,
	parameter int QUO_W = 28,
	parameter int TAG_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [QUO_W-1:0] out_quo,
	output logic [TAG_W-1:0] out_tag
);

	logic             valid_s [0:QUO_W-1];
	logic [NUM_W-1:0] rem_s   [0:QUO_W-1];
	logic [DEN_W-1:0] den_s   [0:QUO_W-1];
	logic [QUO_W-1:0] quo_s   [0:QUO_W-1];
	logic [TAG_W-1:0] tag_s   [0:QUO_W-1];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int B = QUO_W - 1 - k;
		logic             src_valid;
		logic [NUM_W-1:0] src_rem;
		logic [DEN_W-1:0] src_den;
		logic [QUO_W-1:0] src_quo;
		logic [TAG_W-1:0] src_tag;
		logic [NUM_W-1:0] trial;
		logic             take;

		if (k == 0) begin : g_first
			assign src_valid = in_valid;
			assign src_rem   = in_num;
			assign src_den   = in_den;
			assign src_quo   = '0;
			assign src_tag   = in_tag;
		end else begin : g_next
			assign src_valid = valid_s[k-1];
			assign src_rem   = rem_s[k-1];
			assign src_den   = den_s[k-1];
			assign src_quo   = quo_s[k-1];
			assign src_tag   = tag_s[k-1];
		end

		// Compare the shifted remainder against the divisor for this bit.
		assign trial = src_rem >> B;
		assign take  = (trial >= NUM_W'(src_den));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? (src_rem - (NUM_W'(src_den) << B)) : src_rem;
			quo_s[k] <= src_quo | (QUO_W'(take) << B);
			den_s[k] <= src_den;
			tag_s[k] <= src_tag;
		end
	end

	assign out_valid = valid_s[QUO_W-1];
	assign out_quo   = quo_s[QUO_W-1];
	assign out_tag   = tag_s[QUO_W-1];

endmodule

@@ design/gcva_vote.sv @@
// Vote pipeline: walks the candidate window and computes one vote per cycle.
// Depends on gcva_pkg and gcva_div (squared-dot divide and weight divide).
module gcva_vote #(
	parameter int MAX_WIDTH      = 64,
	parameter int MAX_HEIGHT     = 64,
	parameter int GRAD_FRAC_BITS = 14,
	localparam int AWIN_W = $clog2(MAX_WIDTH + 1),
	localparam int AHIN_W = $clog2(MAX_HEIGHT + 1),
	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  gcva_pkg::point_t     point,
	input  logic [AWIN_W-1:0]    win_w,
	input  logic [AHIN_W-1:0]    win_h,
	output gcva_pkg::vote_t      vote,
	output logic [ADDR_W-1:0]    vote_addr
);

	localparam int CX_W   = $clog2(MAX_WIDTH);
	localparam int CY_W   = $clog2(MAX_HEIGHT);
	localparam int CM_W   = (CX_W > CY_W) ? CX_W : CY_W;
	localparam int D_W    = ((CM_W > gcva_pkg::COORD_W) ? CM_W : gcva_pkg::COORD_W) + 1;
	localparam int P_W    = D_W + gcva_pkg::GRAD_W;
	localparam int N_W    = P_W + 1;
	localparam int NP_W   = N_W - 1;
	localparam int SQ_W   = 2 * D_W;
	localparam int R2_W   = SQ_W + 1;
	localparam int UP     = (2 * GRAD_FRAC_BITS < 24) ? (24 - 2 * GRAD_FRAC_BITS) : 0;
	localparam int DN     = (2 * GRAD_FRAC_BITS > 24) ? (2 * GRAD_FRAC_BITS - 24) : 0;
	localparam int NUM1_W = 2 * NP_W + UP;
	localparam int DEN1_W = R2_W + DN;
	localparam int QUO1_W = 2 * gcva_pkg::GRAD_W + 24 - 2 * GRAD_FRAC_BITS;
	localparam int NUM2_W = QUO1_W + gcva_pkg::WEIGHT_W;
	localparam int VS_W   = ((NUM2_W > gcva_pkg::SCORE_W) ? NUM2_W : gcva_pkg::SCORE_W) + 1;
	localparam int TAG_W  = ADDR_W + 1;

	// Candidate walker.
	logic              run_q;
	logic [CX_W-1:0]   cx_q;
	logic [CY_W-1:0]   cy_q;
	logic [ADDR_W-1:0] row_q;
	logic              row_end;
	logic              frame_end;

	assign row_end   = ((AWIN_W'(cx_q) + AWIN_W'(1)) == win_w);
	assign frame_end = row_end && ((AHIN_W'(cy_q) + AHIN_W'(1)) == win_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (run_q && frame_end) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q  <= '0;
			cy_q  <= '0;
			row_q <= '0;
		end else if (run_q) begin
			if (row_end) begin
				cx_q  <= '0;
				cy_q  <= cy_q + 1'b1;
				row_q <= row_q + ADDR_W'(MAX_WIDTH);
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
	end

	// Valid bits of the front stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	// Stage 1: displacement from candidate to point.
	logic signed [D_W-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		dx_s1  <= signed'(D_W'(point.px)) - signed'(D_W'(cx_q));
		dy_s1  <= signed'(D_W'(point.py)) - signed'(D_W'(cy_q));
		tag_s1 <= {frame_end, row_q + ADDR_W'(cx_q)};
	end

	// Stage 2: products with the gradient and squares.
	logic signed [P_W-1:0]  prx_s2, pry_s2;
	logic signed [SQ_W-1:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk) begin
		prx_s2 <= P_W'(dx_s1) * P_W'(point.gx);
		pry_s2 <= P_W'(dy_s1) * P_W'(point.gy);
		sqx_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		sqy_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		tag_s2 <= tag_s1;
	end

	// Stage 3: dot product and squared distance.
	logic signed [N_W-1:0] n_s3;
	logic [R2_W-1:0]       r2_s3;

	always_ff @(posedge clk) begin
		n_s3   <= N_W'(prx_s2) + N_W'(pry_s2);
		r2_s3  <= R2_W'($unsigned(sqx_s2)) + R2_W'($unsigned(sqy_s2));
		tag_s3 <= tag_s2;
	end

	// Stage 4: clip at zero, square, scale into the Q.24 divide operands.
	logic [NP_W-1:0]   npos;
	logic [NUM1_W-1:0] num1_s4;
	logic [DEN1_W-1:0] den1_s4;

	assign npos = (n_s3 > 0) ? n_s3[NP_W-1:0] : '0;

	always_ff @(posedge clk) begin
		num1_s4 <= NUM1_W'((2 * NP_W)'(npos) * (2 * NP_W)'(npos)) << UP;
		// The own position gives a zero numerator; a unit divisor keeps it zero.
		den1_s4 <= (r2_s3 == '0) ? DEN1_W'(1) : (DEN1_W'(r2_s3) << DN);
		tag_s4  <= tag_s3;
	end

	// Squared normalized dot product.
	logic              d1_valid;
	logic [QUO1_W-1:0] d1_quo;
	logic [TAG_W-1:0]  d1_tag;

	gcva_div #(
		.NUM_W(NUM1_W),
		.DEN_W(DEN1_W),
		.QUO_W(QUO1_W),
		.TAG_W(TAG_W)
	) u_div_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.in_num   (num1_s4),
		.in_den   (den1_s4),
		.in_tag   (tag_s4),
		.out_valid(d1_valid),
		.out_quo  (d1_quo),
		.out_tag  (d1_tag)
	);

	// Stage 5: weight multiply (multiplier is one when weighting is off).
	logic [NUM2_W-1:0] prod_s5;

	always_ff @(posedge clk) begin
		prod_s5 <= NUM2_W'(d1_quo) * NUM2_W'(point.mult);
		tag_s5  <= d1_tag;
	end

	// Weight divide.
	logic              d2_valid;
	logic [NUM2_W-1:0] d2_quo;
	logic [TAG_W-1:0]  d2_tag;

	gcva_div #(
		.NUM_W(NUM2_W),
		.DEN_W(gcva_pkg::WEIGHT_W),
		.QUO_W(NUM2_W),
		.TAG_W(TAG_W)
	) u_div_weight (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.in_num   (prod_s5),
		.in_den   (point.divisor),
		.in_tag   (tag_s5),
		.out_valid(d2_valid),
		.out_quo  (d2_quo),
		.out_tag  (d2_tag)
	);

	// Valid bits of the stages around the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= run_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= d1_valid;
			v_s6 <= d2_valid;
		end
	end

	// Stage 6: saturate the vote to the score width.
	logic [gcva_pkg::SCORE_W-1:0] val_s6;

	always_ff @(posedge clk) begin
		val_s6 <= (VS_W'(d2_quo) > VS_W'(gcva_pkg::SCORE_MAX)) ?
			gcva_pkg::SCORE_MAX : gcva_pkg::SCORE_W'(d2_quo);
		tag_s6 <= d2_tag;
	end

	assign vote.valid = v_s6;
	assign vote.last  = tag_s6[ADDR_W];
	assign vote.value = val_s6;
	assign vote_addr  = tag_s6[ADDR_W-1:0];

endmodule

@@ design/gcva_checker.sv @@
// Port-level checker for the gradient center vote accumulator, with its bind.
// Depends on gcva_pkg and the top level's port list.
module gcva_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic signed [gcva_pkg::GRAD_W-1:0] grad_x,
	input logic signed [gcva_pkg::GRAD_W-1:0] grad_y,
	input logic                               last_point,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [gcva_pkg::COORD_W-1:0]       center_x,
	input logic [gcva_pkg::COORD_W-1:0]       center_y,
	input logic [gcva_pkg::SCORE_W-1:0]       best_score
);

	// A pending result request stays until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped before it was taken");

	// A pending result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(center_x) && $stable(center_y) && $stable(best_score))
		else $error("result payload changed while stalled");

	// A last point always starts a readout, so the input closes.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_point |=> !in_ready)
		else $error("input stayed open after a last point");

	// A point with a gradient always starts a voting pass.
	a_vote_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (grad_x != '0 || grad_y != '0) |=> !in_ready)
		else $error("input stayed open after a voting point");

	// A result appears only as the scan ends and the block returns to idle.
	a_report_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared outside the end of a scan");

endmodule

bind gradient_center_vote_accumulator_top gcva_checker u_gcva_checker (.*);
